// File: hw/rtl/tmps_pkg.sv
// shared types and constants for the triangle max path sum block
package tmps_pkg;

  localparam int VALUE_W  = 8;
  localparam int SUM_W    = 15;
  localparam int CFG_W    = 8;
  localparam int MAX_ROWS_DEFAULT = 128;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // apb register map
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_ROW_COUNT = 1'b0;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = CFG_W'(1);

  // position of an entry inside its triangle
  typedef enum logic [1:0] {
    KIND_APEX,
    KIND_LEFT,
    KIND_RIGHT,
    KIND_INNER
  } tmps_kind_t;

  typedef struct packed {
    tmps_kind_t kind;
    logic       last_row;
    logic       emit;
  } tmps_ctl_t;

endpackage

// File: hw/rtl/tmps_if.sv
// item channels: triangle entries in, path sums out
interface tmps_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmps_pkg::VALUE_W-1:0]  value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface tmps_out_if;
  logic                          valid;
  logic                          ready;
  logic [tmps_pkg::SUM_W-1:0]    max_sum;
  modport source (output valid, output max_sum, input ready);
  modport sink   (input valid, input max_sum, output ready);
endinterface

// File: hw/rtl/tmps_front.sv
// front end: accepts entries, tracks row and column, classifies each entry
module tmps_front #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         restart,
  input  logic [tmps_pkg::CFG_W-1:0]   row_count,
  tmps_in_if.sink                      in_ch,
  output logic                         push_valid,
  input  logic                         push_ready,
  output tmps_pkg::tmps_ctl_t          push_ctl,
  output logic [$clog2(MAX_ROWS)-1:0]  push_col,
  output logic [tmps_pkg::VALUE_W-1:0] push_value
);
  import tmps_pkg::*;

  localparam int IDX_W = $clog2(MAX_ROWS);
  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [CMP_W-1:0] rc_ext;
  logic [CMP_W-1:0] rows;
  logic             last_row;
  logic             last_col;
  logic             accept;

  // clamp row count into 1..MAX_ROWS
  always_comb begin
    rc_ext = CMP_W'(row_count);
    if (rc_ext == '0) begin
      rows = CMP_W'(1);
    end else if (rc_ext > CMP_W'(MAX_ROWS)) begin
      rows = CMP_W'(MAX_ROWS);
    end else begin
      rows = rc_ext;
    end
  end

  assign last_row = (CMP_W'(row_r) + CMP_W'(1)) == rows;
  assign last_col = (col_r == row_r);
  assign accept   = in_ch.valid && push_ready;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign push_col    = col_r;
  assign push_value  = in_ch.value;

  always_comb begin
    priority if (row_r == '0) begin
      push_ctl.kind = KIND_APEX;
    end else if (col_r == '0) begin
      push_ctl.kind = KIND_LEFT;
    end else if (last_col) begin
      push_ctl.kind = KIND_RIGHT;
    end else begin
      push_ctl.kind = KIND_INNER;
    end
    push_ctl.last_row = last_row;
    push_ctl.emit     = last_row && last_col;
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        row_nxt = last_row ? '0 : row_r + IDX_W'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: hw/rtl/tmps_queue.sv
// two-entry queue between front end and back end
module tmps_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);
  import tmps_pkg::*;

  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/tmps_back.sv
// back end: row buffer read, parent select, add, base row max, result register
module tmps_back #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  tmps_pkg::tmps_ctl_t          q_ctl,
  input  logic [$clog2(MAX_ROWS)-1:0]  q_col,
  input  logic [tmps_pkg::VALUE_W-1:0] q_value,
  tmps_out_if.source                   out_ch
);
  import tmps_pkg::*;

  localparam int IDX_W = $clog2(MAX_ROWS);

  logic [SUM_W-1:0] row_best_mem [MAX_ROWS];

  // read stage
  logic               s1_v_r;
  tmps_ctl_t          s1_ctl_r;
  logic [IDX_W-1:0]   s1_col_r;
  logic [VALUE_W-1:0] s1_val_r;

  // compute stage
  logic               s2_v_r;
  tmps_ctl_t          s2_ctl_r;
  logic [IDX_W-1:0]   s2_col_r;
  logic [VALUE_W-1:0] s2_val_r;
  logic [SUM_W-1:0]   rd_data_r;
  logic               fwd_v_r;
  logic [SUM_W-1:0]   fwd_data_r;

  logic [SUM_W-1:0]   held_r, held_nxt;
  logic [SUM_W-1:0]   base_max_r, base_max_nxt;
  logic               out_v_r;
  logic [SUM_W-1:0]   out_sum_r;

  logic               out_free, s2_fire, s2_adv, s1_fire, s1_adv;
  logic [SUM_W-1:0]   rd_word, old_here, parent;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;

  assign out_free = !out_v_r || out_ch.ready;
  assign s2_fire  = s2_v_r && (!s2_ctl_r.emit || out_free);
  assign s2_adv   = !s2_v_r || s2_fire;
  assign s1_fire  = s1_v_r && s2_adv;
  assign s1_adv   = !s1_v_r || s1_fire;
  assign q_ready  = s1_adv;

  assign out_ch.valid   = out_v_r;
  assign out_ch.max_sum = out_sum_r;

  // the entry just written by the previous item bypasses the buffer
  assign rd_word = fwd_v_r ? fwd_data_r : rd_data_r;

  always_comb begin
    old_here = '0;
    parent   = '0;
    unique case (s2_ctl_r.kind)
      KIND_APEX: begin
        parent = '0;
      end
      KIND_LEFT: begin
        old_here = rd_word;
        parent   = rd_word;
      end
      KIND_RIGHT: begin
        parent = held_r;
      end
      KIND_INNER: begin
        old_here = rd_word;
        parent   = (held_r > rd_word) ? held_r : rd_word;
      end
      default: begin
        parent = '0;
      end
    endcase
    sum_wide = {1'b0, parent} + (SUM_W + 1)'(s2_val_r);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    held_nxt = old_here;

    base_max_nxt = base_max_r;
    if (s2_ctl_r.last_row) begin
      if (s2_ctl_r.kind == KIND_APEX || s2_ctl_r.kind == KIND_LEFT ||
          sum_sat > base_max_r) begin
        base_max_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      row_best_mem[s2_col_r] <= sum_sat;
    end
    if (s1_fire) begin
      rd_data_r  <= row_best_mem[s1_col_r];
      fwd_v_r    <= s2_fire && (s2_col_r == s1_col_r);
      fwd_data_r <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_ctl_r <= q_ctl;
      s1_col_r <= q_col;
      s1_val_r <= q_value;
    end
    if (s2_adv) begin
      s2_ctl_r <= s1_ctl_r;
      s2_col_r <= s1_col_r;
      s2_val_r <= s1_val_r;
    end
    if (s2_fire && s2_ctl_r.emit) begin
      out_sum_r <= base_max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      held_r     <= '0;
      base_max_r <= '0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= q_valid;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (s2_fire) begin
        held_r     <= held_nxt;
        base_max_r <= base_max_nxt;
      end
      if (s2_fire && s2_ctl_r.emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/triangle_max_path_sum.sv
// top level of the triangle maximum path sum block
//
// Triangle entries arrive on in_ch one per item, row by row and left to right
// (row 0 has one entry, row r has r+1). Each entry adds the larger best sum of
// its two parents in the row above, kept in a one-row buffer of MAX_ROWS words,
// and after the last entry of the base row one item carrying the largest base
// row sum appears on out_ch; the next entry starts a new triangle. The row
// count register (byte address 0, reset value 1, zero read as one row, values
// above MAX_ROWS read as MAX_ROWS) must be written over the cfg_ apb port only
// while the block is idle (not enforced by the block); a write also restarts the
// triangle. The block takes one entry every clock cycle for as long as out_ch
// keeps up; a result reaches out_ch via the queue, read stage, compute stage and
// result register. That rate is set by the single read and single write port of
// the row buffer, which both serve one entry per cycle, with a write-to-read
// bypass covering the second row, whose parent is written as it is read.
// Internally a front end counts rows and columns and classifies each entry, a
// two-entry queue decouples it from the back end, and the back end reads the
// buffer, adds and tracks the base row maximum ahead of a result register. Sums
// saturate at 32767, which only matters when MAX_ROWS is raised beyond 128.
module triangle_max_path_sum #(
  parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tmps_in_if.sink                       in_ch,
  tmps_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tmps_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [tmps_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [tmps_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import tmps_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ROWS);
  localparam int CTL_W  = $bits(tmps_ctl_t);
  localparam int ITEM_W = CTL_W + IDX_W + VALUE_W;

  // configuration register
  logic [CFG_W-1:0] row_count_r;
  logic             cfg_wr;
  logic             cfg_hit_rc;

  // front to queue
  logic               push_valid, push_ready;
  tmps_ctl_t          push_ctl;
  logic [IDX_W-1:0]   push_col;
  logic [VALUE_W-1:0] push_value;

  // queue to back
  logic               q_valid, q_ready;
  logic [ITEM_W-1:0]  q_data;
  tmps_ctl_t          q_ctl;
  logic [IDX_W-1:0]   q_col;
  logic [VALUE_W-1:0] q_value;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_hit_rc = (cfg_paddr[2] == REG_ROW_COUNT);

  // read back, addresses past the register list read zero
  assign cfg_prdata = cfg_hit_rc ? PDATA_W'(row_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROW_COUNT_RESET;
    end else if (cfg_wr && cfg_hit_rc) begin
      row_count_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // row and column tracking, entry classification
  tmps_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr && cfg_hit_rc),
    .row_count  (row_count_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ctl   (push_ctl),
    .push_col   (push_col),
    .push_value (push_value)
  );

  // decoupling queue
  tmps_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_col, push_value}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_ctl   = tmps_ctl_t'(q_data[ITEM_W-1 -: CTL_W]);
  assign q_col   = q_data[VALUE_W +: IDX_W];
  assign q_value = q_data[VALUE_W-1:0];

  // row buffer, sum and base row maximum
  tmps_back #(
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_ctl   (q_ctl),
    .q_col   (q_col),
    .q_value (q_value),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/tmps_checker.sv
// port level checks for the triangle max path sum block, bound to the top
module tmps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tmps_pkg::SUM_W-1:0]    max_sum,
  input logic                          cfg_psel,
  input logic                          cfg_penable,
  input logic                          cfg_pwrite,
  input logic [tmps_pkg::PADDR_W-1:0]  cfg_paddr,
  input logic [tmps_pkg::PDATA_W-1:0]  cfg_pwdata,
  input logic [tmps_pkg::PDATA_W-1:0]  cfg_prdata,
  input logic                          cfg_pready
);
  import tmps_pkg::*;

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(max_sum))
    else $error("result changed while stalled");

  // reset leaves no result pending
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a row count write reads back on the following cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
    (cfg_paddr[2] == REG_ROW_COUNT)
    |=> (cfg_paddr[2] != REG_ROW_COUNT) ||
        (cfg_prdata == PDATA_W'($past(cfg_pwdata[CFG_W-1:0]))))
    else $error("row count read back mismatch");

  // no wait states on the register port
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel |-> cfg_pready)
    else $error("register port stalled");

endmodule

bind triangle_max_path_sum tmps_checker u_tmps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .max_sum     (out_ch.max_sum),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);
